FILE: hdl/go_back_n_congestion_sender_top_macros.svh
// ----------------------------------------------------------------------------
// Go-back-N congestion sender assertion macros
// Shared property wrappers; they sample on clk and are held off during arst_n.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_CONGESTION_SENDER_TOP_MACROS_SVH
`define GO_BACK_N_CONGESTION_SENDER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define GBNCS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gbncs: same-cycle check failed");

`define GBNCS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gbncs: next-cycle check failed");

`else

`define GBNCS_ASSERT_IMP(name, ante, cons)

`define GBNCS_ASSERT_NXT(name, ante, cons)

`endif

`endif

FILE: hdl/gbncs_pkg.sv
// ----------------------------------------------------------------------------
// gbncs_pkg
// Types, register codes and constants of the go-back-N congestion sender.
// ----------------------------------------------------------------------------
package gbncs_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int DUP_LIMIT  = 3;
	localparam int RESULT_CAP = 16;

	localparam int BURST_W     = $clog2(RESULT_CAP + 1);
	localparam int BURST_CAP_I = (MAX_WINDOW < RESULT_CAP) ? MAX_WINDOW : RESULT_CAP;
	localparam logic [BURST_W-1:0] BURST_CAP = BURST_W'(BURST_CAP_I);

	localparam logic [31:0] TIMEOUT_MAX = 32'd4000000000;
	localparam logic [15:0] WINDOW_MAX  = 16'hFFFF;

	// configuration register codes
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_TOTAL_SEGMENTS = 3'd0;
	localparam cfg_idx_t CFG_WINDOW_LIMIT   = 3'd1;
	localparam cfg_idx_t CFG_SEGMENT_BYTES  = 3'd2;
	localparam cfg_idx_t CFG_INIT_TIMEOUT   = 3'd3;
	localparam cfg_idx_t CFG_INIT_THRESHOLD = 3'd4;

	localparam logic [15:0] TOTAL_SEGMENTS_RST = 16'd1;
	localparam logic [4:0]  WINDOW_LIMIT_RST   = 5'd2;
	localparam logic [15:0] SEGMENT_BYTES_RST  = 16'd1460;
	localparam logic [31:0] INIT_TIMEOUT_RST   = 32'd2000000;
	localparam logic [31:0] INIT_THRESHOLD_RST = 32'd64000;

	// event codes
	typedef logic [1:0] mode_t;
	localparam mode_t MODE_START   = 2'd0;
	localparam mode_t MODE_ACK     = 2'd1;
	localparam mode_t MODE_TIMEOUT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC_EST,
		ST_CALC_DIFF,
		ST_CALC_DEV,
		ST_APPLY,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic latch;
		logic calc_est;
		logic calc_diff;
		logic calc_dev;
		logic apply;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic emit_last;
	} status_t;

endpackage

FILE: hdl/go_back_n_congestion_sender_top.sv
// ----------------------------------------------------------------------------
// go_back_n_congestion_sender_top
// Go-back-N sender control with slow start and smoothed RTT timeout.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         event: mode, cumulative ack, RTT sample
// m_axis    out        one result per segment of the burst, or one status
// cfg       in         write-only register port, five registers
//
// An event is sequenced through the latch, three estimator steps and
// the state update, then gives one result per cycle unless m_axis stalls.
// Results leave through a single output register; a stalled m_axis holds
// the burst in place. s_axis is ready only between events.
// Reset is asynchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "go_back_n_congestion_sender_top_macros.svh"

module go_back_n_congestion_sender_top
	import gbncs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // ack_number[15:0], rtt_sample_us[47:16]
	input  logic [1:0]  s_axis_tuser,   // mode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// seq_number[15:0], final_segment[16], window_now[32:17],
	// timeout_now_us[64:33], transfer_done[65], zero[71:66]
	output logic [71:0] m_axis_tdata,
	output logic        m_axis_tuser,   // send_valid
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cmd_t        cmd;
	status_t     status;
	logic [15:0] seq_number;
	logic        final_segment;
	logic [15:0] window_now;
	logic [31:0] timeout_now_us;
	logic        transfer_done;

	gbncs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	gbncs_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_mode            (s_axis_tuser),
		.in_ack_number      (s_axis_tdata[15:0]),
		.in_rtt_sample_us   (s_axis_tdata[47:16]),
		.cmd                (cmd),
		.status             (status),
		.out_ready          (m_axis_tready),
		.out_valid          (m_axis_tvalid),
		.out_send_valid     (m_axis_tuser),
		.out_seq_number     (seq_number),
		.out_final_segment  (final_segment),
		.out_last           (m_axis_tlast),
		.out_window_now     (window_now),
		.out_timeout_now_us (timeout_now_us),
		.out_transfer_done  (transfer_done)
	);

	assign m_axis_tdata = {6'b000000, transfer_done, timeout_now_us, window_now,
		final_segment, seq_number};

	`GBNCS_ASSERT_NXT(a_busy_after_request, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`GBNCS_ASSERT_IMP(a_status_is_last, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
	`GBNCS_ASSERT_IMP(a_final_is_last, m_axis_tvalid && m_axis_tdata[16], m_axis_tlast)
	`GBNCS_ASSERT_NXT(a_out_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

FILE: hdl/gbncs_ctrl.sv
// ----------------------------------------------------------------------------
// gbncs_ctrl
// Event sequencer: latch request, three estimator steps, state update, burst.
// ----------------------------------------------------------------------------
module gbncs_ctrl
	import gbncs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_CALC_EST;
				end
			end
			ST_CALC_EST: begin
				cmd.calc_est = 1'b1;
				state_d      = ST_CALC_DIFF;
			end
			ST_CALC_DIFF: begin
				cmd.calc_diff = 1'b1;
				state_d       = ST_CALC_DEV;
			end
			ST_CALC_DEV: begin
				cmd.calc_dev = 1'b1;
				state_d      = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/gbncs_dp.sv
// ----------------------------------------------------------------------------
// gbncs_dp
// Configuration, sender state, RTT estimator and the result output register.
// ----------------------------------------------------------------------------
module gbncs_dp
	import gbncs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  cfg_idx_t    cfg_index,
	input  logic [31:0] cfg_data,
	input  mode_t       in_mode,
	input  logic [15:0] in_ack_number,
	input  logic [31:0] in_rtt_sample_us,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic        out_ready,
	output logic        out_valid,
	output logic        out_send_valid,
	output logic [15:0] out_seq_number,
	output logic        out_final_segment,
	output logic        out_last,
	output logic [15:0] out_window_now,
	output logic [31:0] out_timeout_now_us,
	output logic        out_transfer_done
);

	// configuration
	logic [15:0] total_segments_q;
	logic [4:0]  window_limit_q;
	logic [15:0] segment_bytes_q;
	logic [31:0] init_timeout_q;
	logic [31:0] init_threshold_q;

	// sender state
	logic [15:0] window_base_q;
	logic [15:0] next_to_send_q;
	logic [15:0] cwnd_q;
	logic [31:0] threshold_q;
	logic [1:0]  partial_cnt_q;
	logic [31:0] srtt_q;
	logic [31:0] rttdev_q;
	logic [31:0] rto_q;

	// request and intermediate results
	mode_t       mode_q;
	logic [15:0] ack_q;
	logic [31:0] sample_q;
	logic [31:0] prod_q;
	logic [31:0] est_q;
	logic [31:0] diff_q;
	logic [31:0] dev_q;

	logic        out_valid_q;
	logic        send_valid_q;
	logic [15:0] seq_q;
	logic        final_q;
	logic        last_q;
	logic [15:0] window_now_q;
	logic [31:0] timeout_now_q;
	logic        done_q;

	logic [4:0]           wl_eff;
	logic [BURST_W-1:0]   burst_wl;
	logic [BURST_W-1:0]   burst;
	logic [16:0]          win_end;
	logic [16:0]          nxt17;
	logic [16:0]          nxt1;
	logic [16:0]          tot17;
	logic                 has_seg;
	logic                 more;
	logic                 emit_last;
	logic [34:0]          est_sum;
	logic [33:0]          dev_sum;
	logic [34:0]          tmo_sum;
	logic [31:0]          tmo_new;
	logic [31:0]          rto_dbl;
	logic [16:0]          grown;
	logic [15:0]          cwnd_grown;
	logic [1:0]           partial_inc;
	logic [15:0]          rewind_to;

	function automatic logic [31:0] clamp_tmo(input logic [34:0] t);
		logic [31:0] r;
		if (t > {3'b000, TIMEOUT_MAX}) begin
			r = TIMEOUT_MAX;
		end else if (t == 35'd0) begin
			r = 32'd1;
		end else begin
			r = t[31:0];
		end
		return r;
	endfunction

	// estimator arithmetic
	assign est_sum = {srtt_q, 3'b000} - {3'b000, srtt_q} + {3'b000, sample_q};
	assign dev_sum = {2'b00, rttdev_q} + {1'b0, rttdev_q, 1'b0} + {2'b00, diff_q};
	assign tmo_sum = {3'b000, est_q} + {1'b0, dev_q, 2'b00};
	assign tmo_new = clamp_tmo(tmo_sum);
	assign rto_dbl = clamp_tmo({2'b00, rto_q, 1'b0});

	// window growth
	assign grown      = (prod_q >= threshold_q) ? ({1'b0, cwnd_q} + 17'd1) : {cwnd_q, 1'b0};
	assign cwnd_grown = grown[16] ? WINDOW_MAX : grown[15:0];

	assign partial_inc = partial_cnt_q + 2'd1;
	assign rewind_to   = (ack_q < window_base_q) ? window_base_q : ack_q;

	// burst window
	assign wl_eff   = (window_limit_q == 5'd0) ? 5'd1 : window_limit_q;
	assign burst_wl = (cwnd_q < {11'd0, wl_eff}) ? BURST_W'(cwnd_q[4:0]) : BURST_W'(wl_eff);
	assign burst    = (burst_wl < BURST_CAP) ? burst_wl : BURST_CAP;
	assign win_end  = {1'b0, window_base_q} + 17'(burst);
	assign nxt17    = {1'b0, next_to_send_q};
	assign nxt1     = nxt17 + 17'd1;
	assign tot17    = {1'b0, total_segments_q};
	assign has_seg  = (nxt17 < win_end) && (nxt17 < tot17);
	assign more     = (nxt1 < win_end) && (nxt1 < tot17);
	assign emit_last = !has_seg || !more;

	assign status.out_free  = !out_valid_q || out_ready;
	assign status.emit_last = emit_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_segments_q <= TOTAL_SEGMENTS_RST;
			window_limit_q   <= WINDOW_LIMIT_RST;
			segment_bytes_q  <= SEGMENT_BYTES_RST;
			init_timeout_q   <= INIT_TIMEOUT_RST;
			init_threshold_q <= INIT_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOTAL_SEGMENTS: total_segments_q <= cfg_data[15:0];
				CFG_WINDOW_LIMIT:   window_limit_q   <= cfg_data[4:0];
				CFG_SEGMENT_BYTES:  segment_bytes_q  <= cfg_data[15:0];
				CFG_INIT_TIMEOUT:   init_timeout_q   <= cfg_data;
				CFG_INIT_THRESHOLD: init_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q  <= '0;
			next_to_send_q <= '0;
			cwnd_q         <= 16'd1;
			threshold_q    <= INIT_THRESHOLD_RST;
			partial_cnt_q  <= '0;
			srtt_q         <= '0;
			rttdev_q       <= '0;
			rto_q          <= INIT_TIMEOUT_RST;
		end else if (cmd.apply) begin
			case (mode_q)
				MODE_START: begin
					window_base_q  <= '0;
					next_to_send_q <= '0;
					cwnd_q         <= 16'd1;
					threshold_q    <= init_threshold_q;
					partial_cnt_q  <= '0;
					srtt_q         <= '0;
					rttdev_q       <= '0;
					rto_q          <= init_timeout_q;
				end
				MODE_ACK: begin
					if (ack_q == next_to_send_q) begin
						partial_cnt_q <= '0;
						if (cwnd_q <= {11'd0, wl_eff}) begin
							cwnd_q   <= cwnd_grown;
							srtt_q   <= est_q;
							rttdev_q <= dev_q;
							rto_q    <= tmo_new;
						end
						window_base_q  <= ack_q;
						next_to_send_q <= ack_q;
					end else if (ack_q < next_to_send_q) begin
						if (32'(partial_inc) >= 32'(DUP_LIMIT)) begin
							partial_cnt_q  <= '0;
							window_base_q  <= rewind_to;
							next_to_send_q <= rewind_to;
						end else begin
							partial_cnt_q <= partial_inc;
						end
					end
				end
				MODE_TIMEOUT: begin
					threshold_q    <= {1'b0, prod_q[31:1]};
					cwnd_q         <= 16'd1;
					partial_cnt_q  <= '0;
					next_to_send_q <= window_base_q;
					rto_q          <= rto_dbl;
				end
				default: ;
			endcase
		end else if (cmd.emit && has_seg) begin
			next_to_send_q <= next_to_send_q + 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q   <= in_mode;
			ack_q    <= in_ack_number;
			sample_q <= in_rtt_sample_us;
		end
		if (cmd.calc_est) begin
			prod_q <= {16'd0, cwnd_q} * {16'd0, segment_bytes_q};
			est_q  <= est_sum[34:3];
		end
		if (cmd.calc_diff) begin
			diff_q <= (sample_q >= est_q) ? (sample_q - est_q) : (est_q - sample_q);
		end
		if (cmd.calc_dev) begin
			dev_q <= dev_sum[33:2];
		end
		if (cmd.emit) begin
			send_valid_q  <= has_seg;
			seq_q         <= has_seg ? next_to_send_q : 16'd0;
			final_q       <= has_seg && (nxt1 == tot17);
			last_q        <= emit_last;
			window_now_q  <= cwnd_q;
			timeout_now_q <= rto_q;
			done_q        <= (window_base_q >= total_segments_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid          = out_valid_q;
	assign out_send_valid     = send_valid_q;
	assign out_seq_number     = seq_q;
	assign out_final_segment  = final_q;
	assign out_last           = last_q;
	assign out_window_now     = window_now_q;
	assign out_timeout_now_us = timeout_now_q;
	assign out_transfer_done  = done_q;

endmodule
